>>> rtl/core/bfpa_pkg.sv
// shared types and constants for the best-fit partition allocator
// no dependencies; imported by every module of the block but bfpa_ram
`default_nettype none

package bfpa_pkg;

  localparam int unsigned IDX_W   = 4;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned CFG_W   = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // sequencer to datapath controls
  typedef struct packed {
    logic start;   // transaction accepted this cycle
    logic proc;    // ram read data valid for pidx
    logic finish;  // scan drained, commit result
  } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/bfpa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bfpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/bfpa_ctrl.sv
// scan sequencer: walks the partitions in use one per cycle through the ram
// depends on bfpa_pkg
`default_nettype none

module bfpa_ctrl #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [bfpa_pkg::CFG_W-1:0]    blocks_in_use_i,
  output bfpa_pkg::ctrl_t                    ctrl_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]      raddr_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]      pidx_o,
  output logic                               busy_o
);

  import bfpa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = AW + 1;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pidx_q, pidx_d;
  logic [CW-1:0]   active_n;
  logic [CW+CFG_W-1:0] cfg_ext;
  logic            issue;

  // counts above the table size act as the table size
  always_comb begin
    cfg_ext = {{CW{1'b0}}, blocks_in_use_i};
    if (cfg_ext > (CW+CFG_W)'(MAX_BLOCKS)) begin
      active_n = CW'(MAX_BLOCKS);
    end else begin
      active_n = cfg_ext[CW-1:0];
    end
  end

  assign issue = (state_q == ST_SCAN) && (cnt_q < active_n);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_d  = cnt_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = cnt_q[AW-1:0];
        end else if (!pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      pidx_q  <= pidx_d;
    end
  end

  assign raddr_o = cnt_q[AW-1:0];
  assign pidx_o  = pidx_q;
  assign busy_o  = (state_q != ST_IDLE);
  assign ctrl_o  = '{start: accept_i, proc: pend_q, finish: (state_q == ST_DONE)};

`ifndef SYNTHESIS
  a_proc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ({1'b0, pidx_q} < active_n))
    else $error("processed index beyond partitions in use");
  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !pend_q)
    else $error("finish while a read is still pending");
  a_issue_then_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> (pend_q && (pidx_q == $past(cnt_q[AW-1:0]))))
    else $error("issued read not processed next cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bfpa_dp.sv
// datapath: busy bits, best-fit tracker, free-size accumulator, result registers
// depends on bfpa_pkg
`default_nettype none

module bfpa_dp #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bfpa_pkg::ctrl_t                  ctrl_i,
  input  wire bfpa_pkg::op_e                    op_i,
  input  wire logic [SIZE_BITS-1:0]             val_i,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0]    pidx_i,
  input  wire logic [SIZE_BITS-1:0]             rdata_i,
  output logic                                  done_o,
  output logic                                  success_o,
  output logic [bfpa_pkg::IDX_W-1:0]            chosen_block_o,
  output logic [bfpa_pkg::VAL_W-1:0]            internal_waste_o,
  output logic [bfpa_pkg::TOTAL_W-1:0]          free_total_o
);

  import bfpa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned TW = SIZE_BITS + AW + 1;

  logic [MAX_BLOCKS-1:0] busy_q, busy_d;
  op_e                   op_q;
  logic [SIZE_BITS-1:0]  val_q;
  logic [TW-1:0]         sum_q, sum_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         best_q, best_d;
  logic [SIZE_BITS-1:0]  bsize_q, bsize_d;
  logic                  done_q;
  logic                  success_q, success_d;
  logic [IDX_W-1:0]      chosen_q, chosen_d;
  logic [VAL_W-1:0]      waste_q, waste_d;
  logic [TOTAL_W-1:0]    total_q, total_d;

  logic                  cur_free;
  logic                  take;
  logic                  hit;
  logic [TW-1:0]         net_sum;
  logic [TW+TOTAL_W-1:0] sum_ext;
  logic [SIZE_BITS-1:0]  diff;
  logic [SIZE_BITS+VAL_W-1:0] diff_ext;
  logic [AW+IDX_W-1:0]   best_ext;

  assign cur_free = !busy_q[pidx_i];
  assign take     = cur_free && (rdata_i >= val_q) && (!found_q || (rdata_i < bsize_q));
  assign hit      = (op_q == OP_ALLOC) && found_q;

  // free total after an allocate leaves out the partition just taken
  assign net_sum  = hit ? (sum_q - TW'(bsize_q)) : sum_q;
  assign sum_ext  = {{TOTAL_W{1'b0}}, net_sum};
  assign diff     = bsize_q - val_q;
  assign diff_ext = {{VAL_W{1'b0}}, diff};
  assign best_ext = {{IDX_W{1'b0}}, best_q};

  always_comb begin
    busy_d    = busy_q;
    sum_d     = sum_q;
    found_d   = found_q;
    best_d    = best_q;
    bsize_d   = bsize_q;
    success_d = success_q;
    chosen_d  = chosen_q;
    waste_d   = waste_q;
    total_d   = total_q;
    if (ctrl_i.start) begin
      sum_d   = '0;
      found_d = 1'b0;
      best_d  = '0;
      if (op_i == OP_RELEASE) begin
        busy_d = '0;
      end
    end
    if (ctrl_i.proc) begin
      if (cur_free) begin
        sum_d = sum_q + TW'(rdata_i);
      end
      if (take) begin
        found_d = 1'b1;
        best_d  = pidx_i;
        bsize_d = rdata_i;
      end
    end
    if (ctrl_i.finish) begin
      success_d = (op_q != OP_ALLOC) || found_q;
      chosen_d  = hit ? best_ext[IDX_W-1:0] : '0;
      waste_d   = hit ? diff_ext[VAL_W-1:0] : '0;
      if (sum_ext > {{TW{1'b0}}, TOTAL_MAX}) begin
        total_d = TOTAL_MAX;
      end else begin
        total_d = sum_ext[TOTAL_W-1:0];
      end
      if (hit) begin
        busy_d[best_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      op_q    <= OP_LOAD;
    end else begin
      busy_q  <= busy_d;
      done_q  <= ctrl_i.finish;
      found_q <= found_d;
      if (ctrl_i.start) begin
        op_q <= op_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      val_q <= val_i;
    end
    sum_q     <= sum_d;
    best_q    <= best_d;
    bsize_q   <= bsize_d;
    success_q <= success_d;
    chosen_q  <= chosen_d;
    waste_q   <= waste_d;
    total_q   <= total_d;
  end

  assign done_o           = done_q;
  assign success_o        = success_q;
  assign chosen_block_o   = chosen_q;
  assign internal_waste_o = waste_q;
  assign free_total_o     = total_q;

`ifndef SYNTHESIS
  a_chosen_was_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.finish && hit) |-> !busy_q[best_q])
    else $error("best-fit choice is already occupied");
  a_chosen_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.finish && hit) |=> busy_q[$past(best_q)])
    else $error("allocated partition not marked occupied");
`endif

endmodule

`default_nettype wire

>>> rtl/core/best_fit_partition_allocator.sv
// top level of the best-fit fixed-partition allocator
// depends on bfpa_pkg, bfpa_ram, bfpa_ctrl, bfpa_dp
//
// usage: present op_i, block_index_i and size_value_i with start high; the
// command is taken at a rising edge where start is high and busy is low.
// op load writes a partition size, allocate takes the smallest free
// partition in use that fits (lowest index on ties), release frees all
// partitions, query only reports. every command gives one result, shown on
// the result ports for exactly one cycle with done_o high; it cannot be held.
// blocks_in_use is written over cfg_valid_i/cfg_data_i, always ready.
// the scan reads one partition per cycle from the size ram, whose read data is
// registered; busy stays high through the scan and the done state, and done_o
// rises as busy falls, also with no partitions in use. the next command
// may be given in the cycle done_o is high. reset frees every partition and
// sets the count to 16; sizes are undefined until loaded, no clearing pass.
`default_nettype none

module best_fit_partition_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      op_i,
  input  wire logic [bfpa_pkg::IDX_W-1:0]      block_index_i,
  input  wire logic [bfpa_pkg::VAL_W-1:0]      size_value_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bfpa_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                 done_o,
  output logic                                 success_o,
  output logic [bfpa_pkg::IDX_W-1:0]           chosen_block_o,
  output logic [bfpa_pkg::VAL_W-1:0]           internal_waste_o,
  output logic [bfpa_pkg::TOTAL_W-1:0]         free_total_o
);

  import bfpa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);

  logic [CFG_W-1:0]           blocks_q;
  logic                       accept;
  op_e                        op;
  ctrl_t                      ctrl;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              pidx;
  logic [SIZE_BITS-1:0]       rdata;
  logic [SIZE_BITS-1:0]       val;
  logic [SIZE_BITS+VAL_W-1:0] val_ext;
  logic [AW+IDX_W-1:0]        idx_ext;
  logic                       idx_ok;
  logic                       we;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      blocks_q <= cfg_data_i;
    end
  end

  assign accept  = start && !busy;
  assign op      = op_e'(op_i);

  // sizes are cut to the stored width
  assign val_ext = {{SIZE_BITS{1'b0}}, size_value_i};
  assign val     = val_ext[SIZE_BITS-1:0];

  // loads outside the table are dropped but still answered
  assign idx_ext = {{AW{1'b0}}, block_index_i};
  assign idx_ok  = idx_ext < (AW+IDX_W)'(MAX_BLOCKS);
  assign we      = accept && (op == OP_LOAD) && idx_ok;

  bfpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (val),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bfpa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .blocks_in_use_i (blocks_q),
    .ctrl_o          (ctrl),
    .raddr_o         (raddr),
    .pidx_o          (pidx),
    .busy_o          (busy)
  );

  bfpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .op_i             (op),
    .val_i            (val),
    .pidx_i           (pidx),
    .rdata_i          (rdata),
    .done_o           (done_o),
    .success_o        (success_o),
    .chosen_block_o   (chosen_block_o),
    .internal_waste_o (internal_waste_o),
    .free_total_o     (free_total_o)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a transaction is in flight");
`endif

endmodule

`default_nettype wire

>>> tb/best_fit_partition_allocator_test.sv
// self-checking testbench for the best-fit partition allocator: a driver feeds
// queued commands, a monitor checks every result against a built-in predictor
// depends on bfpa_pkg and best_fit_partition_allocator
`default_nettype none

module best_fit_partition_allocator_test;
  import bfpa_pkg::*;

  localparam int NUM_PARTS      = 16;
  localparam int SETTLE_CYCLES  = NUM_PARTS + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 85;

  typedef struct {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] size;
  } command_t;

  typedef struct {
    logic               success;
    logic [IDX_W-1:0]   chosen;
    logic [VAL_W-1:0]   waste;
    logic [TOTAL_W-1:0] total;
  } alloc_result_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cmd_start     = 1'b0;
  logic [1:0]         cmd_op        = '0;
  logic [IDX_W-1:0]   cmd_index     = '0;
  logic [VAL_W-1:0]   cmd_size      = '0;
  logic               cfg_valid     = 1'b0;
  logic [CFG_W-1:0]   cfg_data      = '0;
  logic               busy;
  logic               cfg_ready_o;
  logic               done_o;
  logic               success_o;
  logic [IDX_W-1:0]   chosen_block_o;
  logic [VAL_W-1:0]   internal_waste_o;
  logic [TOTAL_W-1:0] free_total_o;

  // predictor state
  logic [VAL_W-1:0]   part_size [NUM_PARTS];
  logic               part_busy [NUM_PARTS];
  logic [CFG_W-1:0]   part_count = CFG_RESET;

  command_t           command_queue[$];
  alloc_result_t      expected_results[$];
  logic               no_gaps          = 1'b0;
  int                 error_count      = 0;
  int                 cmds_accepted    = 0;
  int                 alloc_count      = 0;
  int                 alloc_fail_count = 0;
  int                 settings_applied = 0;
  int                 stall_cycles     = 0;

  best_fit_partition_allocator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (cmd_start),
    .busy             (busy),
    .op_i             (cmd_op),
    .block_index_i    (cmd_index),
    .size_value_i     (cmd_size),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data),
    .done_o           (done_o),
    .success_o        (success_o),
    .chosen_block_o   (chosen_block_o),
    .internal_waste_o (internal_waste_o),
    .free_total_o     (free_total_o)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic alloc_result_t predict_partition_op(op_e op, logic [IDX_W-1:0] idx,
                                                         logic [VAL_W-1:0] val);
    alloc_result_t r;
    int            n;
    int            best;
    logic [TOTAL_W:0] sum;
    r = '{success: 1'b1, chosen: '0, waste: '0, total: '0};
    n = (part_count > NUM_PARTS) ? NUM_PARTS : int'(part_count);
    best = -1;
    case (op)
      OP_LOAD: part_size[idx] = val;
      OP_ALLOC: begin
        alloc_count++;
        for (int i = 0; i < n; i++) begin
          if (!part_busy[i] && part_size[i] >= val &&
              (best < 0 || part_size[i] < part_size[best])) begin
            best = i;
          end
        end
        if (best >= 0) begin
          part_busy[best] = 1'b1;
          r.chosen = best[IDX_W-1:0];
          r.waste  = part_size[best] - val;
        end else begin
          r.success = 1'b0;
          alloc_fail_count++;
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < NUM_PARTS; i++) part_busy[i] = 1'b0;
      end
      default: ;
    endcase
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (!part_busy[i]) begin
        sum += part_size[i];
        if (sum > TOTAL_MAX) sum = TOTAL_MAX;
      end
    end
    r.total = sum[TOTAL_W-1:0];
    return r;
  endfunction

  // driver: holds a command until the block takes it, predicts on acceptance
  always @(posedge clk) begin : cmd_driver
    command_t      next_cmd;
    alloc_result_t res;
    logic          taken;
    if (!rst_n) begin
      cmd_start <= 1'b0;
    end else begin
      taken = cmd_start && !busy;
      if (taken) begin
        res = predict_partition_op(op_e'(cmd_op), cmd_index, cmd_size);
        expected_results.insert(expected_results.size(), res);
        cmds_accepted++;
      end
      if (cmd_start && !taken) begin
        // keep presenting the same command
      end else if (command_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 16)) begin
        next_cmd = command_queue.pop_front();
        cmd_start <= 1'b1;
        cmd_op    <= next_cmd.op;
        cmd_index <= next_cmd.idx;
        cmd_size  <= next_cmd.size;
      end else begin
        cmd_start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, so every done_o cycle is a transaction
  always @(posedge clk) begin : result_monitor
    alloc_result_t exp_r;
    if (rst_n) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no command outstanding");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (success_o !== exp_r.success) begin
            $error("success: expected %0d, got %0d", exp_r.success, success_o);
            error_count++;
          end
          if (chosen_block_o !== exp_r.chosen) begin
            $error("chosen_block: expected %0d, got %0d", exp_r.chosen, chosen_block_o);
            error_count++;
          end
          if (internal_waste_o !== exp_r.waste) begin
            $error("internal_waste: expected %0d, got %0d", exp_r.waste, internal_waste_o);
            error_count++;
          end
          if (free_total_o !== exp_r.total) begin
            $error("free_total: expected %0d, got %0d", exp_r.total, free_total_o);
            error_count++;
          end
        end
      end
      if ((cmd_start && !busy) || done_o || (cfg_valid && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("best_fit_partition_allocator verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic void push_cmd(op_e op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] size);
    command_t c;
    c.op   = op;
    c.idx  = idx;
    c.size = size;
    command_queue.insert(command_queue.size(), c);
  endfunction

  // mix of corner sizes, tie-prone sizes, full-range random and small random sizes
  function automatic logic [VAL_W-1:0] pick_size();
    logic [VAL_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = '1;
      2, 3:    s = VAL_W'($urandom);
      4, 5:    s = VAL_W'(64 << $urandom_range(0, 2));
      default: s = VAL_W'($urandom_range(0, 2000));
    endcase
    return s;
  endfunction

  function automatic void queue_random_commands(int count);
    int  roll;
    op_e op;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      op = OP_LOAD;
      else if (roll < 70) op = OP_ALLOC;
      else if (roll < 78) op = OP_RELEASE;
      else                op = OP_QUERY;
      push_cmd(op, IDX_W'($urandom_range(0, NUM_PARTS - 1)), pick_size());
    end
  endfunction

  task automatic wait_all_results();
    do @(negedge clk);
    while (command_queue.size() != 0 || cmd_start || expected_results.size() != 0);
  endtask

  task automatic set_partition_count(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    part_count = value;
    settings_applied++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] counts [7];
    logic [VAL_W-1:0] dsize;
    for (int i = 0; i < NUM_PARTS; i++) begin
      part_size[i] = '0;
      part_busy[i] = 1'b0;
    end
    counts = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd8, CFG_W'($urandom_range(2, 31))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // no partition takes part while sizes are loaded, so nothing unloaded is read
    set_partition_count('0);
    for (int i = 0; i < NUM_PARTS; i++) begin
      if (i == 0)      dsize = '0;
      else if (i == 1) dsize = '1;
      else             dsize = VAL_W'(((i % 4) + 1) * 100);
      push_cmd(OP_LOAD, IDX_W'(i), dsize);
    end
    push_cmd(OP_ALLOC, '0, '0);
    push_cmd(OP_QUERY, '0, '0);
    wait_all_results();

    set_partition_count(5'd16);
    push_cmd(OP_QUERY, '0, '0);
    push_cmd(OP_ALLOC, '0, '0);          // zero request takes the size-zero partition
    push_cmd(OP_ALLOC, '0, 16'd150);     // ties between equal sizes
    push_cmd(OP_ALLOC, '0, '1);
    push_cmd(OP_ALLOC, '0, '1);          // largest partition already taken
    push_cmd(OP_LOAD, 4'd1, 16'd7);      // reload of an occupied partition
    push_cmd(OP_RELEASE, '0, '0);
    push_cmd(OP_QUERY, '0, '0);
    wait_all_results();

    for (int ph = 0; ph < 7; ph++) begin
      set_partition_count(counts[ph]);
      no_gaps = (ph == 3);
      queue_random_commands(PHASE_ITEMS);
      wait_all_results();
    end
    no_gaps = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    $display("ran %0d commands with %0d allocations (%0d without a fit)",
             cmds_accepted, alloc_count, alloc_fail_count);
    $display("over %0d partition count settings, including 0, 1 and above the table size",
             settings_applied);
    if (error_count == 0) begin
      $display("best_fit_partition_allocator verification clean");
    end else begin
      $display("best_fit_partition_allocator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> best_fit_partition_allocator.f
rtl/core/bfpa_pkg.sv
rtl/core/bfpa_ram.sv
rtl/core/bfpa_ctrl.sv
rtl/core/bfpa_dp.sv
rtl/core/best_fit_partition_allocator.sv
tb/best_fit_partition_allocator_test.sv
